// ----- design/dik_pkg.sv -----
// shared types, constants and the square-root step for the delta inverse kinematics block
package dik_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int HEIGHT_WIDTH = COORD_WIDTH + 1;
   localparam int SQ_WIDTH     = 2 * COORD_WIDTH;
   localparam int DIST_WIDTH   = SQ_WIDTH + 1;
   localparam int REM_WIDTH    = COORD_WIDTH + 3;
   localparam int NUM_TOWERS   = 3;
   localparam int CSR_IDX_WIDTH = 3;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_TOWER_A = 3'd0,
      CSR_TOWER_B = 3'd1,
      CSR_TOWER_C = 3'd2,
      CSR_ROD_A   = 3'd3,
      CSR_ROD_B   = 3'd4,
      CSR_ROD_C   = 3'd5
   } csr_index_type;

   // partial square root of one tower
   typedef struct packed {
      logic [REM_WIDTH-1:0]   rem;
      logic [COORD_WIDTH-1:0] root;
   } root_type;

   // one restoring square-root step: bring down two radicand bits, try one root bit
   function automatic root_type root_step(root_type cur, logic [1:0] pair);
      logic [REM_WIDTH-1:0] shifted;
      logic [REM_WIDTH-1:0] trial;
      root_type             nxt;
      shifted = {cur.rem[REM_WIDTH-3:0], pair};
      trial   = {1'b0, cur.root, 2'b01};
      if (shifted >= trial) begin
         nxt.rem  = shifted - trial;
         nxt.root = {cur.root[COORD_WIDTH-2:0], 1'b1};
      end else begin
         nxt.rem  = shifted;
         nxt.root = {cur.root[COORD_WIDTH-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// ----- design/dik_req_if.sv -----
// effector position word channel
interface dik_req_if;
   import dik_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- design/dik_rsp_if.sv -----
// carriage height word channel
interface dik_rsp_if;
   import dik_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [HEIGHT_WIDTH-1:0] height_a;
   logic signed [HEIGHT_WIDTH-1:0] height_b;
   logic signed [HEIGHT_WIDTH-1:0] height_c;
   logic [NUM_TOWERS-1:0]          unreachable_mask;
   modport source (output valid, height_a, height_b, height_c, unreachable_mask, input ready);
   modport sink   (input valid, height_a, height_b, height_c, unreachable_mask, output ready);
endinterface

// ----- design/delta_inverse_kinematics.sv -----
// Delta inverse kinematics: one effector point in, three carriage heights out.
// The block takes one word per cycle unless the output stalls; it is a 28-stage
// pipeline: tower offsets, squares, radicand and reach check, 24 restoring
// square-root stages (one root bit each), then add of z with saturation into
// the output register. A stage holds its word only while the next stage is full
// and stalled, so bubbles close up under backpressure. The user must write tower
// positions and squared rod lengths through the csr port only while no word is
// in flight (not enforced); indexes beyond the six registers are ignored.
module delta_inverse_kinematics
   import dik_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   dik_req_if.sink                  req,
   dik_rsp_if.source                rsp,
   input  logic                     csr_we,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [SQ_WIDTH-1:0]      csr_wdata
);

   localparam int NUM_STAGES = COORD_WIDTH + 4;
   localparam int ROOT_FIRST = 3;

   // configuration registers
   logic [SQ_WIDTH-1:0] tower_pos_ff [NUM_TOWERS];
   logic [SQ_WIDTH-1:0] rod_sq_ff    [NUM_TOWERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TOWERS; t++) begin
            tower_pos_ff[t] <= '0;
            rod_sq_ff[t]    <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOWER_A: tower_pos_ff[0] <= csr_wdata;
            CSR_TOWER_B: tower_pos_ff[1] <= csr_wdata;
            CSR_TOWER_C: tower_pos_ff[2] <= csr_wdata;
            CSR_ROD_A:   rod_sq_ff[0]    <= csr_wdata;
            CSR_ROD_B:   rod_sq_ff[1]    <= csr_wdata;
            CSR_ROD_C:   rod_sq_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage flow control
   logic valid_ff [NUM_STAGES];
   logic adv      [NUM_STAGES];

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) valid_ff[s] <= 1'b0;
      end else begin
         if (adv[0]) valid_ff[0] <= req.valid;
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (adv[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   assign req.ready = adv[0];

   // z travels alongside every stage before the last one
   logic signed [COORD_WIDTH-1:0] z_ff [NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv[0]) z_ff[0] <= req.pos_z;
      for (int s = 1; s < NUM_STAGES - 1; s++) begin
         if (adv[s]) z_ff[s] <= z_ff[s-1];
      end
   end

   // stage 0: absolute offsets from point to each tower
   logic [COORD_WIDTH-1:0] dx_ff [NUM_TOWERS];
   logic [COORD_WIDTH-1:0] dy_ff [NUM_TOWERS];
   logic [COORD_WIDTH-1:0] dx_in [NUM_TOWERS];
   logic [COORD_WIDTH-1:0] dy_in [NUM_TOWERS];

   always_comb begin
      for (int t = 0; t < NUM_TOWERS; t++) begin
         logic signed [COORD_WIDTH:0] ddx;
         logic signed [COORD_WIDTH:0] ddy;
         ddx = $signed({tower_pos_ff[t][SQ_WIDTH-1], tower_pos_ff[t][SQ_WIDTH-1:COORD_WIDTH]})
             - $signed({req.pos_x[COORD_WIDTH-1], req.pos_x});
         ddy = $signed({tower_pos_ff[t][COORD_WIDTH-1], tower_pos_ff[t][COORD_WIDTH-1:0]})
             - $signed({req.pos_y[COORD_WIDTH-1], req.pos_y});
         dx_in[t] = ddx[COORD_WIDTH] ? COORD_WIDTH'(-ddx) : ddx[COORD_WIDTH-1:0];
         dy_in[t] = ddy[COORD_WIDTH] ? COORD_WIDTH'(-ddy) : ddy[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // stage 1: squares
   logic [SQ_WIDTH-1:0] sqx_ff [NUM_TOWERS];
   logic [SQ_WIDTH-1:0] sqy_ff [NUM_TOWERS];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int t = 0; t < NUM_TOWERS; t++) begin
            sqx_ff[t] <= dx_ff[t] * dx_ff[t];
            sqy_ff[t] <= dy_ff[t] * dy_ff[t];
         end
      end
   end

   // stage 2: squared distance, reach check and radicand
   logic [SQ_WIDTH-1:0]   rad_ff [ROOT_FIRST-1:NUM_STAGES-3][NUM_TOWERS];
   logic [NUM_TOWERS-1:0] mask_ff [ROOT_FIRST-1:NUM_STAGES-2];
   logic [SQ_WIDTH-1:0]   rad_in [NUM_TOWERS];
   logic [NUM_TOWERS-1:0] mask_in;

   always_comb begin
      for (int t = 0; t < NUM_TOWERS; t++) begin
         logic [DIST_WIDTH-1:0] dist_sq;
         logic [DIST_WIDTH-1:0] diff;
         dist_sq = {1'b0, sqx_ff[t]} + {1'b0, sqy_ff[t]};
         diff = {1'b0, rod_sq_ff[t]} - dist_sq;
         mask_in[t] = dist_sq > {1'b0, rod_sq_ff[t]};
         rad_in[t]  = mask_in[t] ? '0 : diff[SQ_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         rad_ff[ROOT_FIRST-1]  <= rad_in;
         mask_ff[ROOT_FIRST-1] <= mask_in;
      end
   end

   // square-root stages, one root bit per stage from the top
   root_type root_ff [ROOT_FIRST:NUM_STAGES-2][NUM_TOWERS];

   for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_root
      localparam int S  = ROOT_FIRST + k;
      localparam int HI = 2 * (COORD_WIDTH - 1 - k) + 1;
      root_type root_in [NUM_TOWERS];

      if (k == 0) begin : g_first
         always_comb begin
            for (int t = 0; t < NUM_TOWERS; t++) begin
               root_in[t] = root_step('0, rad_ff[S-1][t][HI -: 2]);
            end
         end
      end else begin : g_next
         always_comb begin
            for (int t = 0; t < NUM_TOWERS; t++) begin
               root_in[t] = root_step(root_ff[S-1][t], rad_ff[S-1][t][HI -: 2]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv[S]) begin
            mask_ff[S] <= mask_ff[S-1];
            root_ff[S] <= root_in;
         end
      end

      // radicand carried on while bits remain to bring down
      if (k < COORD_WIDTH - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv[S]) rad_ff[S] <= rad_ff[S-1];
         end
      end
   end

   // last stage: height = z + root, saturated
   logic signed [HEIGHT_WIDTH-1:0] height_ff [NUM_TOWERS];
   logic [NUM_TOWERS-1:0]          mask_out_ff;
   logic signed [HEIGHT_WIDTH-1:0] height_in [NUM_TOWERS];

   localparam logic signed [HEIGHT_WIDTH:0] HMAX =
      (HEIGHT_WIDTH + 1)'((1 << (HEIGHT_WIDTH - 1)) - 1);
   localparam logic signed [HEIGHT_WIDTH:0] HMIN = -HMAX - (HEIGHT_WIDTH + 1)'(1);

   always_comb begin
      for (int t = 0; t < NUM_TOWERS; t++) begin
         logic signed [HEIGHT_WIDTH:0] sum;
         sum = $signed({{2{z_ff[NUM_STAGES-2][COORD_WIDTH-1]}}, z_ff[NUM_STAGES-2]})
             + $signed({2'b00, root_ff[NUM_STAGES-2][t].root});
         if (sum > HMAX)      height_in[t] = HMAX[HEIGHT_WIDTH-1:0];
         else if (sum < HMIN) height_in[t] = HMIN[HEIGHT_WIDTH-1:0];
         else                 height_in[t] = sum[HEIGHT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES-1]) begin
         height_ff   <= height_in;
         mask_out_ff <= mask_ff[NUM_STAGES-2];
      end
   end

   assign rsp.valid            = valid_ff[NUM_STAGES-1];
   assign rsp.height_a         = height_ff[0];
   assign rsp.height_b         = height_ff[1];
   assign rsp.height_c         = height_ff[2];
   assign rsp.unreachable_mask = mask_out_ff;

endmodule

// ----- tb/tb_delta_inverse_kinematics.sv -----
// testbench for the delta inverse kinematics block with a self-checking scoreboard
`timescale 1ns / 1ps

// predicts carriage heights for accepted points and checks the result words
class height_scoreboard;
   typedef struct packed {
      logic signed [dik_pkg::HEIGHT_WIDTH-1:0] height_a;
      logic signed [dik_pkg::HEIGHT_WIDTH-1:0] height_b;
      logic signed [dik_pkg::HEIGHT_WIDTH-1:0] height_c;
      logic [dik_pkg::NUM_TOWERS-1:0]          unreachable_mask;
   } heights_type;

   logic [dik_pkg::SQ_WIDTH-1:0] tower_pos[dik_pkg::NUM_TOWERS];
   logic [dik_pkg::SQ_WIDTH-1:0] rod_sq[dik_pkg::NUM_TOWERS];
   heights_type expected_heights[$];
   int errors;
   int checked;
   int unreach_seen;
   int sat_seen;

   function new();
      foreach (tower_pos[t]) begin
         tower_pos[t] = '0;
         rod_sq[t]    = '0;
      end
      errors = 0;
      checked = 0;
      unreach_seen = 0;
      sat_seen = 0;
   endfunction

   // mirror of a register write; indexes past the rods are dropped
   function void write_reg(logic [dik_pkg::CSR_IDX_WIDTH-1:0] idx,
                           logic [dik_pkg::SQ_WIDTH-1:0] data);
      if (idx < dik_pkg::NUM_TOWERS)
         tower_pos[idx] = data;
      else if (idx < 2 * dik_pkg::NUM_TOWERS)
         rod_sq[idx - dik_pkg::NUM_TOWERS] = data;
   endfunction

   // floor of the square root, one root bit at a time
   function longint root_floor(longint n);
      longint res;
      longint cand;
      res = 0;
      for (int b = dik_pkg::COORD_WIDTH - 1; b >= 0; b--) begin
         cand = res | (longint'(1) << b);
         if (cand * cand <= n) res = cand;
      end
      return res;
   endfunction

   // one tower: radicand, reach check, root plus z, saturation
   function logic [dik_pkg::HEIGHT_WIDTH-1:0] carriage_height(int t, longint x, longint y,
                                                             longint z, output bit unreach);
      longint tx, ty, dx, dy, dist_sq, rod, h;
      longint hmax;
      tx   = longint'($signed(tower_pos[t][dik_pkg::SQ_WIDTH-1:dik_pkg::COORD_WIDTH]));
      ty   = longint'($signed(tower_pos[t][dik_pkg::COORD_WIDTH-1:0]));
      dx   = tx - x;
      dy   = ty - y;
      dist_sq = dx * dx + dy * dy;
      rod  = longint'({16'b0, rod_sq[t]});
      hmax = (longint'(1) << (dik_pkg::HEIGHT_WIDTH - 1)) - 1;
      h    = z;
      unreach = dist_sq > rod;
      if (!unreach) h = z + root_floor(rod - dist_sq);
      if (h > hmax) begin
         h = hmax;
         sat_seen++;
      end
      if (h < -hmax - 1) h = -hmax - 1;
      return h[dik_pkg::HEIGHT_WIDTH-1:0];
   endfunction

   // accepted point: queue its expected heights
   function void note_point(logic signed [dik_pkg::COORD_WIDTH-1:0] x,
                            logic signed [dik_pkg::COORD_WIDTH-1:0] y,
                            logic signed [dik_pkg::COORD_WIDTH-1:0] z);
      heights_type e;
      bit u0, u1, u2;
      e.height_a = carriage_height(0, x, y, z, u0);
      e.height_b = carriage_height(1, x, y, z, u1);
      e.height_c = carriage_height(2, x, y, z, u2);
      e.unreachable_mask = {u2, u1, u0};
      if (e.unreachable_mask != 0) unreach_seen++;
      expected_heights.push_back(e);
   endfunction

   // accepted result word against the oldest expectation
   function void check_heights(heights_type act);
      heights_type e;
      if (expected_heights.size() == 0) begin
         $error("result word with no point pending");
         errors++;
         return;
      end
      e = expected_heights.pop_front();
      checked++;
      if (act.height_a !== e.height_a) begin
         $error("height_a expected %0d actual %0d", e.height_a, act.height_a);
         errors++;
      end
      if (act.height_b !== e.height_b) begin
         $error("height_b expected %0d actual %0d", e.height_b, act.height_b);
         errors++;
      end
      if (act.height_c !== e.height_c) begin
         $error("height_c expected %0d actual %0d", e.height_c, act.height_c);
         errors++;
      end
      if (act.unreachable_mask !== e.unreachable_mask) begin
         $error("unreachable_mask expected %0b actual %0b",
                e.unreachable_mask, act.unreachable_mask);
         errors++;
      end
   endfunction
endclass

module tb_delta_inverse_kinematics;
   import dik_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNUSED_IDX = 3'd6;
   localparam int PIPE_DRAIN  = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [SQ_WIDTH-1:0] csr_wdata;

   dik_req_if req ();
   dik_rsp_if rsp ();

   delta_inverse_kinematics dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   height_scoreboard sb = new();
   int cycle_count = 0;
   int burst_left = 0;
   bit no_gaps = 0;
   int hold_req = 0;
   int hold_done = 0;
   int hold_left = 0;
   int ready_mode = 0;
   int points_sent = 0;

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // known values on every input from time zero
   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 0;
      req.pos_x = '0;
      req.pos_y = '0;
      req.pos_z = '0;
      rsp.ready = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (cycle_count % 50 == 0) ready_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 0;
         end else begin
            case (ready_mode)
               0: rsp.ready = 1;
               1: rsp.ready = ($urandom_range(0, 1) == 1);
               2: rsp.ready = ($urandom_range(0, 4) == 0);
               default: rsp.ready = ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // result word sampling
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_heights({rsp.height_a, rsp.height_b, rsp.height_c, rsp.unreachable_mask});
   end

   // one point word, with burst gaps in front
   task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input logic signed [COORD_WIDTH-1:0] z);
      int gap;
      if (!no_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req.valid = 0;
         end
         burst_left = $urandom_range(1, 24);
      end else if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
      req.valid = 1;
      req.pos_x = x;
      req.pos_y = y;
      req.pos_z = z;
      do @(posedge clock); while (!req.ready);
      sb.note_point(x, y, z);
      points_sent++;
   endtask

   // wait for every result, then let the pipeline go quiet
   task automatic drain();
      @(negedge clock);
      req.valid = 0;
      while (sb.expected_heights.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [SQ_WIDTH-1:0] data);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we = 0;
   endtask

   // all six registers plus a write to an unused index
   task automatic program_towers(input logic [SQ_WIDTH-1:0] ta, input logic [SQ_WIDTH-1:0] tb,
                                 input logic [SQ_WIDTH-1:0] tc, input logic [SQ_WIDTH-1:0] ra,
                                 input logic [SQ_WIDTH-1:0] rb, input logic [SQ_WIDTH-1:0] rc);
      write_csr(CSR_TOWER_A, ta);
      write_csr(CSR_TOWER_B, tb);
      write_csr(CSR_TOWER_C, tc);
      write_csr(CSR_ROD_A, ra);
      write_csr(CSR_ROD_B, rb);
      write_csr(CSR_ROD_C, rc);
      write_csr(CSR_UNUSED_IDX, rand_word());
   endtask

   function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
      return COORD_WIDTH'($urandom);
   endfunction

   // random register-wide value
   function automatic logic [SQ_WIDTH-1:0] rand_word();
      return SQ_WIDTH'({$urandom, $urandom});
   endfunction

   // coordinate spread evenly over plus and minus span
   function automatic logic signed [COORD_WIDTH-1:0] span_coord(input int span);
      return COORD_WIDTH'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // mostly points near the work area, some anywhere
   task automatic random_points(input int count, input int span);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_point(rand_coord(), rand_coord(), rand_coord());
         else
            send_point(span_coord(span), span_coord(span), span_coord(span));
      end
   endtask

   localparam logic signed [COORD_WIDTH-1:0] TWR_X = 354724;
   localparam logic signed [COORD_WIDTH-1:0] TWR_Y = 204800;
   localparam logic signed [COORD_WIDTH-1:0] TWR_R = 409600;
   localparam logic [SQ_WIDTH-1:0] ROD_250 = 48'd1048576000000;

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset settings: towers at origin, zero rods, so the origin column has zero radicand
      send_point(0, 0, 0);
      send_point(0, 0, COORD_MAX);
      send_point(0, 0, COORD_MIN);
      send_point(1, 0, 5);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN, 0);
      drain();

      // realistic machine, 100 mm radius, 250 mm rods
      program_towers({-TWR_X, -TWR_Y}, {TWR_X, -TWR_Y}, {24'sd0, TWR_R},
                     ROD_250, ROD_250, ROD_250);
      send_point(0, 0, 0);
      send_point(-TWR_X, -TWR_Y, 0);
      send_point(TWR_X, -TWR_Y, 100);
      send_point(0, TWR_R, -100);
      send_point(0, 0, COORD_MAX);
      send_point(0, 0, COORD_MIN);
      send_point(COORD_MAX, 0, 0);
      send_point(0, COORD_MIN, 0);
      send_point(0, 4096000, 0);
      drain();
      random_points(300, 1 << 20);
      drain();

      // receiver holds off while the sender keeps pushing
      no_gaps = 1;
      hold_req++;
      random_points(120, 1 << 20);
      no_gaps = 0;
      drain();

      // extreme towers and full rods: high saturation
      program_towers({COORD_MAX, COORD_MIN}, {COORD_MIN, COORD_MAX}, {COORD_MAX, COORD_MAX},
                     {SQ_WIDTH{1'b1}}, {SQ_WIDTH{1'b1}}, {SQ_WIDTH{1'b1}});
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(COORD_MIN, COORD_MAX, COORD_MAX);
      send_point(COORD_MAX, COORD_MAX, 0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      drain();
      random_points(300, 1 << 23);
      drain();

      // random settings, each held for a batch of points
      for (int p = 0; p < 4; p++) begin
         program_towers(rand_word(), rand_word(), rand_word(),
                        rand_word(), rand_word(), rand_word());
         random_points(160, 1 << ($urandom_range(12, 23)));
         drain();
      end

      // back to zero registers
      program_towers('0, '0, '0, '0, '0, '0);
      random_points(20, 1 << 12);
      drain();

      $display("covered %0d points, %0d results checked", points_sent, sb.checked);
      $display("%0d points with unreachable towers, %0d saturated heights",
               sb.unreach_seen, sb.sat_seen);
      if (sb.errors == 0 && sb.expected_heights.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
